// ===== rtl/core/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the sphere pair collision checker
// Holds the controller states, the controller-to-datapath command bundle and
// the register map.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned MarginBits  = 20;
  localparam int unsigned RadiusBits  = 20;
  localparam int unsigned LinkBits    = 8;
  localparam int unsigned DistBits    = 27;
  localparam int unsigned IndexBits   = 6;
  localparam int unsigned AddrBits    = 3;
  localparam int unsigned RsumBits    = RadiusBits + 1;
  localparam int unsigned ThrBits     = RadiusBits + 2;
  localparam int unsigned Th2Bits     = 2 * ThrBits;
  localparam longint     DistMax      = 64'sd67108863;

  localparam logic RegMargin  = 1'b0;
  localparam logic RegExclude = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_WAIT,
    ST_MUL,
    ST_SUM,
    ST_SQRT,
    ST_UPD,
    ST_NEXT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
    logic mul_en;
    logic sum_en;
    logic sqrt_step;
    logic upd_en;
    logic out_load;
    logic ovf;
  } dp_cmd_t;

endpackage

// ===== rtl/core/spc_if.sv =====
// ----------------------------------------------------------------------------
// spc_sphere_if / spc_result_if: valid/ready channels of the checker
// One sphere per input beat, one summary per result beat.
// ----------------------------------------------------------------------------
interface spc_sphere_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_BITS-1:0]   center_x;
  logic signed [COORD_BITS-1:0]   center_y;
  logic signed [COORD_BITS-1:0]   center_z;
  logic        [19:0]             radius;
  logic        [7:0]              link_id;
  logic                           last_sphere;

  modport source (output valid, center_x, center_y, center_z, radius, link_id,
                  last_sphere, input ready);
  modport sink   (input valid, center_x, center_y, center_z, radius, link_id,
                  last_sphere, output ready);
endinterface

interface spc_result_if;
  logic               valid;
  logic               ready;
  logic               collision;
  logic signed [26:0] min_distance;
  logic        [5:0]  nearest_first;
  logic        [5:0]  nearest_second;
  logic               no_pairs;
  logic               overflow;

  modport source (output valid, collision, min_distance, nearest_first,
                  nearest_second, no_pairs, overflow, input ready);
  modport sink   (input valid, collision, min_distance, nearest_first,
                  nearest_second, no_pairs, overflow, output ready);
endinterface

// ===== rtl/core/spc_ctrl.sv =====
// ----------------------------------------------------------------------------
// spc_ctrl: sequencer of the pair sweep
// Counts stored spheres, walks pairs (i<j) and steps the datapath through
// read, square, sum, square root and update.
// ----------------------------------------------------------------------------
module spc_ctrl
  import spc_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = 64,
  parameter int unsigned SQRT_STEPS  = 26
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             in_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic                             skip_i,
  output dp_cmd_t                          cmd_o,
  output logic [$clog2(MAX_SPHERES)-1:0]   wr_addr_o,
  output logic [$clog2(MAX_SPHERES)-1:0]   rd_a_o,
  output logic [$clog2(MAX_SPHERES)-1:0]   rd_b_o
);

  localparam int unsigned IW  = $clog2(MAX_SPHERES);
  localparam int unsigned CW  = $clog2(MAX_SPHERES + 1);
  localparam int unsigned SW  = $clog2(SQRT_STEPS + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [IW-1:0]   i_q, i_d, j_q, j_d;
  logic [SW-1:0]   step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign wr_addr_o   = count_q[IW-1:0];
  assign rd_a_o      = i_q;
  assign rd_b_o      = j_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.ovf   = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < CW'(MAX_SPHERES)) begin
            cmd_o.wr_en = 1'b1;
            count_d     = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.clr = 1'b1;
        i_d       = '0;
        j_d       = IW'(1);
        state_d   = (count_q < CW'(2)) ? ST_OUT : ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        // read data registered; same-link test resolves here
        state_d = skip_i ? ST_NEXT : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        step_d       = '0;
        state_d      = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == SW'(SQRT_STEPS - 1)) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd_en = 1'b1;
        state_d      = ST_NEXT;
      end
      ST_NEXT: begin
        if (CW'(j_q) == count_q - 1'b1) begin
          if (CW'(i_q) == count_q - CW'(2)) begin
            state_d = ST_OUT;
          end else begin
            i_d     = i_q + 1'b1;
            j_d     = i_q + IW'(2);
            state_d = ST_READ;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          count_d        = '0;
          ovf_d          = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/spc_datapath.sv =====
// ----------------------------------------------------------------------------
// spc_datapath: sphere store and pair arithmetic
// Dual-read sphere memory, squared distance, collision threshold, a
// bit-per-cycle square root and the running nearest-pair tracker.
// ----------------------------------------------------------------------------
module spc_datapath
  import spc_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = 64,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                                clk_i,
  input  dp_cmd_t                             cmd_i,
  input  logic [$clog2(MAX_SPHERES)-1:0]      wr_addr_i,
  input  logic [$clog2(MAX_SPHERES)-1:0]      rd_a_i,
  input  logic [$clog2(MAX_SPHERES)-1:0]      rd_b_i,
  input  logic signed [COORD_BITS-1:0]        center_x_i,
  input  logic signed [COORD_BITS-1:0]        center_y_i,
  input  logic signed [COORD_BITS-1:0]        center_z_i,
  input  logic [RadiusBits-1:0]               radius_i,
  input  logic [LinkBits-1:0]                 link_id_i,
  input  logic [MarginBits-1:0]               margin_i,
  input  logic                                exclude_i,
  output logic                                skip_o,
  output logic                                collision_o,
  output logic signed [DistBits-1:0]          min_distance_o,
  output logic [IndexBits-1:0]                nearest_first_o,
  output logic [IndexBits-1:0]                nearest_second_o,
  output logic                                no_pairs_o,
  output logic                                overflow_o
);

  localparam int unsigned IW  = $clog2(MAX_SPHERES);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned MW  = 3 * CB + RadiusBits + LinkBits;
  localparam int unsigned SQW = 2 * CB + 2;
  localparam int unsigned RW  = CB + 2;
  localparam int unsigned D2W = 2 * RW;
  localparam int unsigned CMW = (D2W > Th2Bits) ? D2W : Th2Bits;
  localparam int unsigned DW  = RW + 2;
  localparam int unsigned EW  = (DW > 28) ? DW : 28;
  localparam int unsigned XW  = (IW > IndexBits) ? IW : IndexBits;

  typedef struct packed {
    logic signed [CB-1:0]   x;
    logic signed [CB-1:0]   y;
    logic signed [CB-1:0]   z;
    logic [RadiusBits-1:0]  r;
    logic [LinkBits-1:0]    link;
  } sphere_t;

  logic [MW-1:0]       mem_q [MAX_SPHERES];
  sphere_t             a_q, b_q;
  logic [SQW-1:0]      sqx_q, sqy_q, sqz_q;
  logic [Th2Bits-1:0]  th2_q;
  logic [RsumBits-1:0] rsum_q;
  logic [D2W-1:0]      sh_q;
  logic [RW+1:0]       rem_q;
  logic [RW-1:0]       root_q;
  logic                coll_q, found_q;
  logic signed [DW-1:0] best_q;
  logic [IW-1:0]       bi_q, bj_q, pi_q, pj_q;

  logic signed [CB:0]  dx, dy, dz;
  logic [CB:0]         mx, my, mz;
  logic [ThrBits-1:0]  thr;
  logic [D2W-1:0]      d2;
  logic [RW+1:0]       rem_n, trial;
  logic signed [DW-1:0] pair_dist;
  logic signed [EW-1:0] best_ext;
  logic [XW-1:0]       bi_ext, bj_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[wr_addr_i] <= {center_x_i, center_y_i, center_z_i, radius_i, link_id_i};
    if (cmd_i.rd_en) begin
      a_q  <= sphere_t'(mem_q[rd_a_i]);
      b_q  <= sphere_t'(mem_q[rd_b_i]);
      pi_q <= rd_a_i;
      pj_q <= rd_b_i;
    end
  end

  assign skip_o = exclude_i && (a_q.link == b_q.link);

  always_comb begin
    dx  = (CB+1)'(b_q.x) - (CB+1)'(a_q.x);
    dy  = (CB+1)'(b_q.y) - (CB+1)'(a_q.y);
    dz  = (CB+1)'(b_q.z) - (CB+1)'(a_q.z);
    mx  = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
    my  = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
    mz  = dz[CB] ? (CB+1)'(-dz) : (CB+1)'(dz);
    thr = ThrBits'(a_q.r) + ThrBits'(b_q.r) + ThrBits'(margin_i);
    d2  = D2W'(sqx_q) + D2W'(sqy_q) + D2W'(sqz_q);
    rem_n = {rem_q[RW-1:0], sh_q[D2W-1 -: 2]};
    trial = {root_q, 2'b01};
    pair_dist = $signed({2'b00, root_q}) - $signed(DW'(rsum_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      sqx_q  <= SQW'(mx) * SQW'(mx);
      sqy_q  <= SQW'(my) * SQW'(my);
      sqz_q  <= SQW'(mz) * SQW'(mz);
      th2_q  <= Th2Bits'(thr) * Th2Bits'(thr);
      rsum_q <= RsumBits'(a_q.r) + RsumBits'(b_q.r);
    end
    if (cmd_i.sum_en) begin
      sh_q   <= d2;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sh_q <= {sh_q[D2W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (cmd_i.clr) begin
      coll_q  <= 1'b0;
      found_q <= 1'b0;
      best_q  <= '0;
      bi_q    <= '0;
      bj_q    <= '0;
    end else begin
      if (cmd_i.sum_en && (CMW'(d2) <= CMW'(th2_q))) coll_q <= 1'b1;
      if (cmd_i.upd_en && (!found_q || pair_dist < best_q)) begin
        found_q <= 1'b1;
        best_q  <= pair_dist;
        bi_q    <= pi_q;
        bj_q    <= pj_q;
      end
    end
  end

  assign best_ext = EW'(best_q);
  assign bi_ext   = XW'(bi_q);
  assign bj_ext   = XW'(bj_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      collision_o      <= coll_q;
      no_pairs_o       <= !found_q;
      overflow_o       <= cmd_i.ovf;
      nearest_first_o  <= bi_ext[IndexBits-1:0];
      nearest_second_o <= bj_ext[IndexBits-1:0];
      if (!found_q)                          min_distance_o <= '0;
      else if (best_ext > EW'(DistMax))      min_distance_o <= DistBits'(DistMax);
      else                                   min_distance_o <= best_ext[DistBits-1:0];
    end
  end

endmodule

// ===== rtl/core/sphere_pair_collision_checker.sv =====
// ----------------------------------------------------------------------------
// sphere_pair_collision_checker: all-pairs sphere collision summary
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Load spheres one beat each while the checker is idle; the beat flagged
// last_sphere starts a sweep over every stored pair (i<j), and the input
// stays stalled until the summary is placed in the output register. Each
// evaluated pair steps through read, square, sum, the bit-per-cycle square
// root unit and update; when link exclusion is set, a pair whose spheres
// share a link goes from the read straight to the next pair. Spheres
// beyond MAX_SPHERES are dropped and flagged.
module sphere_pair_collision_checker
  import spc_pkg::*;
#(
  parameter int unsigned MAX_SPHERES = 64,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spc_sphere_if.sink            sphere_i,
  spc_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrBits-1:0]   paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned IW = $clog2(MAX_SPHERES);

  logic [MarginBits-1:0] margin_q;
  logic                  exclude_q;
  dp_cmd_t               cmd;
  logic [IW-1:0]         wr_addr, rd_a, rd_b;
  logic                  skip;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q  <= '0;
      exclude_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegMargin:  margin_q  <= pwdata[MarginBits-1:0];
        RegExclude: exclude_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMargin:  prdata = 32'(margin_q);
      RegExclude: prdata = 32'(exclude_q);
      default:    prdata = '0;
    endcase
  end

  spc_ctrl #(
    .MAX_SPHERES (MAX_SPHERES),
    .SQRT_STEPS  (COORD_BITS + 2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sphere_i.valid),
    .in_ready_o  (sphere_i.ready),
    .in_last_i   (sphere_i.last_sphere),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .skip_i      (skip),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  spc_datapath #(
    .MAX_SPHERES (MAX_SPHERES),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .wr_addr_i        (wr_addr),
    .rd_a_i           (rd_a),
    .rd_b_i           (rd_b),
    .center_x_i       (sphere_i.center_x),
    .center_y_i       (sphere_i.center_y),
    .center_z_i       (sphere_i.center_z),
    .radius_i         (sphere_i.radius),
    .link_id_i        (sphere_i.link_id),
    .margin_i         (margin_q),
    .exclude_i        (exclude_q),
    .skip_o           (skip),
    .collision_o      (result_o.collision),
    .min_distance_o   (result_o.min_distance),
    .nearest_first_o  (result_o.nearest_first),
    .nearest_second_o (result_o.nearest_second),
    .no_pairs_o       (result_o.no_pairs),
    .overflow_o       (result_o.overflow)
  );

endmodule

// ===== rtl/core/spc_checker.sv =====
// ----------------------------------------------------------------------------
// spc_checker: port-level checks for the sphere pair collision checker
// Bound to the top level; watches the result channel and the config port.
// ----------------------------------------------------------------------------
module spc_checker #(
  parameter int unsigned MAX_SPHERES = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        collision,
  input logic [26:0] min_distance,
  input logic [5:0]  nearest_first,
  input logic [5:0]  nearest_second,
  input logic        no_pairs,
  input logic        pready
);

  // stalled result beat holds its min_distance and no_pairs fields
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(min_distance) && $stable(no_pairs))
    else $error("result changed while stalled");

  // empty summary carries zeroed distance fields
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && no_pairs |-> !collision && (min_distance == '0) &&
      (nearest_first == '0) && (nearest_second == '0))
    else $error("no_pairs summary with nonzero fields");

  // nearest pair is ordered when indices are not folded
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !no_pairs |-> (MAX_SPHERES > 64) || (nearest_first < nearest_second))
    else $error("nearest pair out of order");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sphere_pair_collision_checker spc_checker #(.MAX_SPHERES(MAX_SPHERES)) u_spc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (result_o.valid),
  .out_ready      (result_o.ready),
  .collision      (result_o.collision),
  .min_distance   (result_o.min_distance),
  .nearest_first  (result_o.nearest_first),
  .nearest_second (result_o.nearest_second),
  .no_pairs       (result_o.no_pairs),
  .pready         (pready)
);
